// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication or plain property on every rising clock edge out of reset.
`define PTME_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds out of reset.
`define PTME_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define PTME_ASSERT(lbl, clk, rstn, prop, msg)
`define PTME_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: sv/ptme_pkg.sv
`default_nettype none

package ptme_pkg;

    localparam int PG_W      = 36;
    localparam int IDX_W     = 9;
    localparam int ENTRY_W   = 64;
    localparam int OFFSET_W  = 12;
    localparam int STEP_BITS = 4;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_PAGES = 1'b1;

    localparam logic [1:0] LVL_ROOT = 2'd0;
    localparam logic [1:0] LVL_PD   = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_RDWAIT,
        S_MOD,
        S_CHECK,
        S_PWRITE,
        S_ZERO,
        S_LEAF
    } state_t;

    typedef struct packed {
        logic            start;
        logic [PG_W-1:0] value;
    } mod_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_rsp_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [PG_W-1:0] vp,
                                                     input logic [1:0]      lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = vp[35:27];
            2'd1:    idx = vp[26:18];
            2'd2:    idx = vp[17:9];
            default: idx = vp[8:0];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: sv/ptme_ram.sv
`default_nettype none

module ptme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/ptme_page_mod.sv
`default_nettype none

module ptme_page_mod
    import ptme_pkg::*;
#(
    parameter int MODULUS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mod_req_t                     req,
    output mod_rsp_t                          rsp,
    output logic      [$clog2(MODULUS)-1:0]   remainder
);

    localparam int R_W   = $clog2(MODULUS);
    localparam int STEPS = PG_W / STEP_BITS;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [R_W:0]     MOD_V     = (R_W + 1)'(MODULUS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PG_W-1:0]  val_reg, val_next;
    logic [R_W-1:0]   rem_reg, rem_next;
    logic [R_W-1:0]   rem_step;

    always_comb
    begin
        logic [R_W:0] w;
        rem_step = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            w = {rem_step, val_reg[PG_W-1-i]};
            if (w >= MOD_V)
            begin
                w = w - MOD_V;
            end
            rem_step = w[R_W-1:0];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        rem_next    = rem_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            val_next    = req.value;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            rem_next = rem_step;
            val_next = {val_reg[PG_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy  = active_reg;
    assign rsp.done  = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: sv/page_table_map_engine_top.sv
// Channel   | Signals                                                  | Transfer
// ----------+----------------------------------------------------------+-------------------
// request   | op virtual_page physical_page write/exec/user_allowed    | start && !busy
// result    | status leaf_value invalidate_page tables_added           | done (one cycle)
// config    | cfg_wdata                                                | cfg_we
//
// A request whose walk finds all three parent entries present does, per level, one table
// read and a pass of the shared modulo unit, then the capacity check and the leaf write.
// Each new table adds a parent write and a one-entry-per-cycle clear of the 512-entry
// page through the single write port. After reset the whole store (TABLE_PAGES * 512
// entries) is cleared with busy high; cfg_we is taken at any time. The receiver cannot
// stall: done is a one-cycle strobe.
`default_nettype none

`include "assert_macros.svh"

module page_table_map_engine_top
    import ptme_pkg::*;
#(
    parameter int TABLE_PAGES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              op,
    input  wire logic [PG_W-1:0]   virtual_page,
    input  wire logic [PG_W-1:0]   physical_page,
    input  wire logic              write_allowed,
    input  wire logic              exec_allowed,
    input  wire logic              user_allowed,
    output logic                   done,
    output logic                   status,
    output logic [ENTRY_W-1:0]     leaf_value,
    output logic [PG_W-1:0]        invalidate_page,
    output logic [1:0]             tables_added,
    input  wire logic              cfg_we,
    input  wire logic [PG_W-1:0]   cfg_wdata
);

    localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);
    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(TABLE_PAGES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX   = {IDX_W{1'b1}};
    localparam logic [CNT_W:0]    PAGES_V    = (CNT_W + 1)'(TABLE_PAGES);
    localparam logic [CNT_W-1:0]  FIRST_FREE = CNT_W'(1);

    state_t state_reg, state_next;

    logic [PG_W-1:0]    base_reg;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [ADDR_W-1:0]  sweep_reg, sweep_next;
    logic [1:0]         lvl_reg, lvl_next;
    logic [1:0]         needed_reg, needed_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [PG_W-1:0]    vp_reg, vp_next;
    logic [ENTRY_W-1:0] leaf_reg, leaf_next;

    logic               done_reg, done_next;
    logic               status_reg, status_next;
    logic [ENTRY_W-1:0] leaf_out_reg, leaf_out_next;
    logic [PG_W-1:0]    inval_reg, inval_next;
    logic [1:0]         tables_reg, tables_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    mod_req_t           mod_req;
    mod_rsp_t           mod_rsp;
    logic [PAGE_W-1:0]  mod_page;

    logic               no_room;
    logic [PG_W-1:0]    new_phys;
    logic               accept;

    assign accept   = start && (state_reg == S_IDLE);
    assign no_room  = ({1'b0, free_reg} + (CNT_W + 1)'(needed_reg)) > PAGES_V;
    assign new_phys = base_reg + PG_W'(free_reg);

    ptme_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ptme_page_mod #(
        .MODULUS (TABLE_PAGES)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .rsp       (mod_rsp),
        .remainder (mod_page)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                state_next = mem_rdata[0] ? S_MOD : S_CHECK;
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    state_next = (lvl_reg == LVL_PD) ? S_CHECK : S_RD;
                end
            end
            S_CHECK:
            begin
                if (no_room)
                begin
                    state_next = S_IDLE;
                end
                else if (needed_reg == 2'd0)
                begin
                    state_next = S_LEAF;
                end
                else
                begin
                    state_next = S_PWRITE;
                end
            end
            S_PWRITE:
            begin
                state_next = S_ZERO;
            end
            S_ZERO:
            begin
                if (sweep_reg[IDX_W-1:0] == LAST_IDX)
                begin
                    state_next = (lvl_reg == LVL_PD) ? S_LEAF : S_PWRITE;
                end
            end
            S_LEAF:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        free_next     = free_reg;
        sweep_next    = sweep_reg;
        lvl_next      = lvl_reg;
        needed_next   = needed_reg;
        page_next     = page_reg;
        vp_next       = vp_reg;
        leaf_next     = leaf_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        leaf_out_next = leaf_out_reg;
        inval_next    = inval_reg;
        tables_next   = tables_reg;
        mem_we        = 1'b0;
        mem_waddr     = {page_reg, level_index(vp_reg, lvl_reg)};
        mem_wdata     = '0;
        mem_raddr     = {page_reg, level_index(vp_reg, lvl_reg)};
        mod_req.start = 1'b0;
        mod_req.value = mem_rdata[OFFSET_W+PG_W-1:OFFSET_W] - base_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    vp_next     = virtual_page;
                    lvl_next    = LVL_ROOT;
                    page_next   = '0;
                    needed_next = 2'd0;
                    leaf_next   = '0;
                    if (op == OP_MAP)
                    begin
                        leaf_next = {~exec_allowed, 15'b0, physical_page, 9'b0,
                                     user_allowed, write_allowed, 1'b1};
                    end
                end
            end
            S_RDWAIT:
            begin
                if (mem_rdata[0])
                begin
                    mod_req.start = 1'b1;
                end
                else
                begin
                    needed_next = 2'd3 - lvl_reg;
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    page_next = mod_page;
                    lvl_next  = lvl_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                if (no_room)
                begin
                    done_next     = 1'b1;
                    status_next   = STATUS_NO_PAGES;
                    leaf_out_next = '0;
                    inval_next    = vp_reg;
                    tables_next   = 2'd0;
                end
            end
            S_PWRITE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {16'b0, new_phys, 9'b0, 3'b011};
                page_next  = free_reg[PAGE_W-1:0];
                free_next  = free_reg + 1'b1;
                sweep_next = '0;
            end
            S_ZERO:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {page_reg, sweep_reg[IDX_W-1:0]};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[IDX_W-1:0] == LAST_IDX && lvl_reg != LVL_PD)
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            S_LEAF:
            begin
                mem_we        = 1'b1;
                mem_waddr     = {page_reg, level_index(vp_reg, 2'd3)};
                mem_wdata     = leaf_reg;
                done_next     = 1'b1;
                status_next   = STATUS_DONE;
                leaf_out_next = leaf_reg;
                inval_next    = vp_reg;
                tables_next   = needed_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            base_reg  <= '0;
            free_reg  <= FIRST_FREE;
            sweep_reg <= '0;
            lvl_reg   <= LVL_ROOT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            sweep_reg <= sweep_next;
            lvl_reg   <= lvl_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        needed_reg   <= needed_next;
        page_reg     <= page_next;
        vp_reg       <= vp_next;
        leaf_reg     <= leaf_next;
        status_reg   <= status_next;
        leaf_out_reg <= leaf_out_next;
        inval_reg    <= inval_next;
        tables_reg   <= tables_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign leaf_value      = leaf_out_reg;
    assign invalidate_page = inval_reg;
    assign tables_added    = tables_reg;

    `PTME_ASSERT(a_done_src, clk, rst_n, done_reg |-> ($past(state_reg) == S_LEAF || $past(state_reg) == S_CHECK), "result strobe without leaf write or capacity failure")
    `PTME_ASSERT(a_alloc_room, clk, rst_n, (state_reg == S_PWRITE) |-> ({1'b0, free_reg} < PAGES_V), "table page allocated beyond the store")
    `PTME_ASSERT(a_fail_clean, clk, rst_n, (done_reg && status_reg == STATUS_NO_PAGES) |-> (tables_reg == 2'd0 && leaf_out_reg == '0), "failed request reports allocation or leaf")
    `PTME_ASSERT(a_mod_range, clk, rst_n, mod_rsp.done |-> ({1'b0, mod_page} < (PAGE_W + 1)'(TABLE_PAGES)), "walked page outside the store")
    `PTME_ASSERT_NEVER(a_mod_idle, clk, rst_n, mod_rsp.busy && state_reg != S_MOD, "modulo unit running outside the walk")

endmodule

`default_nettype wire

// File: tb/page_table_map_engine_top_tb.sv
`default_nettype none

module page_table_map_engine_top_tb;
    import ptme_pkg::*;

    localparam int TABLE_PAGES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int WATCHDOG_LIMIT    = 150000;
    localparam int SETTLE_CYCLES     = 100;
    localparam int RANDOM_ITEMS      = 300;

    localparam logic [63:0] PTE_PRESENT = 64'h0000_0000_0000_0001;
    localparam logic [63:0] PTE_WRITE   = 64'h0000_0000_0000_0002;
    localparam logic [63:0] PTE_USER    = 64'h0000_0000_0000_0004;
    localparam logic [63:0] PTE_NO_EXEC = 64'h8000_0000_0000_0000;
    localparam logic [35:0] PAGE_ALL    = 36'hF_FFFF_FFFF;

    typedef struct packed {
        logic        status;
        logic [63:0] leaf;
        logic [35:0] invalidate;
        logic [1:0]  added;
    } map_outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              op = OP_MAP;
    logic [PG_W-1:0]   virtual_page = '0;
    logic [PG_W-1:0]   physical_page = '0;
    logic              write_allowed = 1'b0;
    logic              exec_allowed = 1'b0;
    logic              user_allowed = 1'b0;
    logic              done;
    logic              status;
    logic [ENTRY_W-1:0] leaf_value;
    logic [PG_W-1:0]   invalidate_page;
    logic [1:0]        tables_added;
    logic              cfg_we = 1'b0;
    logic [PG_W-1:0]   cfg_wdata = '0;

    logic [63:0]  table_mem [TABLE_PAGES*ENTRIES_PER_TABLE];
    int unsigned  free_page = 1;
    logic [35:0]  base_page = '0;

    map_outcome_t pending_outcomes[$];
    logic [35:0]  known_pages[$];

    int sender_idle_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int sent_map = 0;
    int sent_unmap = 0;
    int outcomes_seen = 0;
    int no_page_rejects = 0;
    int tables_made = 0;
    int base_writes = 0;

    page_table_map_engine_top #(
        .TABLE_PAGES(TABLE_PAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .virtual_page(virtual_page),
        .physical_page(physical_page),
        .write_allowed(write_allowed),
        .exec_allowed(exec_allowed),
        .user_allowed(user_allowed),
        .done(done),
        .status(status),
        .leaf_value(leaf_value),
        .invalidate_page(invalidate_page),
        .tables_added(tables_added),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic logic [35:0] rand36();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[35:0];
    endfunction

    function automatic int unsigned table_slot(int unsigned pg, logic [35:0] vp, int lvl);
        logic [35:0] idx;
        idx = (vp >> (27 - 9 * lvl)) & 36'h1FF;
        return pg * ENTRIES_PER_TABLE + int'(idx);
    endfunction

    function automatic int unsigned store_page(logic [63:0] entry);
        logic [35:0] rel;
        rel = entry[47:12] - base_page;
        return int'(rel % TABLE_PAGES);
    endfunction

    function automatic map_outcome_t walk_tables(logic o, logic [35:0] vp, logic [35:0] pp,
                                                 logic wr, logic ex, logic us);
        map_outcome_t r;
        int unsigned  pg, need, first_missing, sl, np, k;
        int           lvl;
        logic [63:0]  e, leaf;
        logic [35:0]  phys;
        pg = 0;
        first_missing = 3;
        for (lvl = 0; lvl < 3 && first_missing == 3; lvl++)
        begin
            e = table_mem[table_slot(pg, vp, lvl)];
            if (e[0])
                pg = store_page(e);
            else
                first_missing = lvl;
        end
        need = 3 - first_missing;
        r.invalidate = vp;
        if (need > TABLE_PAGES - free_page)
        begin
            r.status = STATUS_NO_PAGES;
            r.leaf = '0;
            r.added = '0;
            return r;
        end
        pg = 0;
        for (lvl = 0; lvl < 3; lvl++)
        begin
            sl = table_slot(pg, vp, lvl);
            if (lvl >= first_missing)
            begin
                np = free_page;
                phys = base_page + 36'(np);
                free_page++;
                table_mem[sl] = {16'h0, phys, 12'h0} | PTE_PRESENT | PTE_WRITE;
                for (k = 0; k < ENTRIES_PER_TABLE; k++)
                    table_mem[np * ENTRIES_PER_TABLE + k] = '0;
                pg = np;
            end
            else
                pg = store_page(table_mem[sl]);
        end
        leaf = '0;
        if (o == OP_MAP)
        begin
            leaf = {16'h0, pp, 12'h0} | PTE_PRESENT;
            if (wr)
                leaf |= PTE_WRITE;
            if (us)
                leaf |= PTE_USER;
            if (!ex)
                leaf |= PTE_NO_EXEC;
        end
        table_mem[table_slot(pg, vp, 3)] = leaf;
        r.status = STATUS_DONE;
        r.leaf = leaf;
        r.added = need[1:0];
        return r;
    endfunction

    function automatic logic [35:0] pick_virtual_page();
        logic [35:0] vp, near;
        int          roll;
        roll = $urandom_range(99);
        vp = rand36();
        if (known_pages.size() == 0 || roll >= 96)
            return vp;
        near = known_pages[$urandom_range(known_pages.size() - 1)];
        if (roll < 40)
            return near;
        if (roll < 70)
            return {near[35:9], vp[8:0]};
        if (roll < 86)
            return {near[35:18], vp[17:0]};
        return {near[35:27], vp[26:0]};
    endfunction

    task automatic send_request(input logic o, input logic [35:0] vp, input logic [35:0] pp,
                                input logic wr, input logic ex, input logic us);
        map_outcome_t r;
        int           gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 40) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        op <= o;
        virtual_page <= vp;
        physical_page <= pp;
        write_allowed <= wr;
        exec_allowed <= ex;
        user_allowed <= us;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        r = walk_tables(o, vp, pp, wr, ex, us);
        pending_outcomes.push_back(r);
        known_pages.push_back(vp);
        if (o == OP_MAP)
            sent_map++;
        else
            sent_unmap++;
        if (r.status == STATUS_NO_PAGES)
            no_page_rejects++;
        tables_made += r.added;
    endtask

    // hold off the sender until every outstanding transfer has returned
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_table_base(input logic [35:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        base_page = value;
        base_writes++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    task automatic test_directed_walks();
        int k;
        sender_idle_pct = 0;
        while (busy !== 1'b0)
            @(posedge clk);
        write_table_base('0);
        send_request(OP_MAP, '0, '0, 1'b0, 1'b0, 1'b0);
        send_request(OP_MAP, PAGE_ALL, PAGE_ALL, 1'b1, 1'b1, 1'b1);
        send_request(OP_MAP, 36'h0_0000_0001, 36'hA_AAAA_AAAA, 1'b1, 1'b0, 1'b0);
        send_request(OP_MAP, 36'h0_0000_0200, 36'h5_5555_5555, 1'b0, 1'b1, 1'b0);
        send_request(OP_MAP, 36'h0_0004_0000, rand36(), 1'b1, 1'b1, 1'b0);
        send_request(OP_MAP, 36'h5_5555_5555, 36'h5_5555_5555, 1'b0, 1'b1, 1'b1);
        send_request(OP_UNMAP, 36'hA_AAAA_AAAA, PAGE_ALL, 1'b1, 1'b1, 1'b1);
        send_request(OP_UNMAP, '0, PAGE_ALL, 1'b1, 1'b0, 1'b1);
        send_request(OP_MAP, '0, rand36(), 1'b0, 1'b1, 1'b0);
        send_request(OP_UNMAP, 36'h0_0000_0001, 36'hA_AAAA_AAAA, 1'b0, 1'b0, 1'b0);
        send_request(OP_MAP, PAGE_ALL, '0, 1'b0, 1'b0, 1'b0);
        for (k = 0; k < 8; k++)
            send_request(OP_MAP, 36'(k + 2), rand36(), k[0], k[1], k[2]);
    endtask

    // stale parent entries resolve to shifted store pages after a base change
    task automatic test_table_base_wrap();
        sender_idle_pct = 10;
        write_table_base(PAGE_ALL);
        send_request(OP_MAP, 36'h1_2345_6789, rand36(), 1'b1, 1'b0, 1'b1);
        send_request(OP_MAP, 36'h1_2345_6700, rand36(), 1'b0, 1'b1, 1'b1);
        send_request(OP_MAP, '0, rand36(), 1'b1, 1'b1, 1'b1);
        send_request(OP_UNMAP, PAGE_ALL, rand36(), 1'b0, 1'b0, 1'b0);
        write_table_base(rand36());
        send_request(OP_MAP, 36'h1_2345_6789, rand36(), 1'b1, 1'b1, 1'b0);
        send_request(OP_MAP, 36'h0_0000_0200, rand36(), 1'b0, 1'b0, 1'b1);
        write_table_base('0);
        send_request(OP_MAP, 36'h5_5555_5555, rand36(), 1'b1, 1'b0, 1'b0);
        send_request(OP_UNMAP, 36'h0_0004_0000, rand36(), 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input logic [35:0] base, input int count);
        int   n;
        logic o;
        write_table_base(base);
        sender_idle_pct = idle_pct;
        for (n = 0; n < count; n++)
        begin
            o = ($urandom_range(99) < 25) ? OP_UNMAP : OP_MAP;
            send_request(o, pick_virtual_page(), rand36(), $urandom_range(1), $urandom_range(1),
                         $urandom_range(1));
        end
    endtask

    task automatic test_table_exhaustion();
        int          n, extra;
        logic [35:0] vp, near;
        extra = 0;
        sender_idle_pct = 20;
        for (n = 0; n < 120 && extra < 10; n++)
        begin
            vp = rand36();
            if (n % 2 == 1 && known_pages.size() != 0)
            begin
                near = known_pages[$urandom_range(known_pages.size() - 1)];
                vp = {near[35:18], vp[17:0]};
            end
            send_request(OP_MAP, vp, rand36(), $urandom_range(1), $urandom_range(1),
                         $urandom_range(1));
            if (free_page == TABLE_PAGES)
                extra++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        map_outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            outcomes_seen++;
            if (pending_outcomes.size() == 0)
                report_mismatch("result with nothing pending, page", '0, 64'(invalidate_page));
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(status));
                if (leaf_value !== want.leaf)
                    report_mismatch("leaf_value", want.leaf, leaf_value);
                if (invalidate_page !== want.invalidate)
                    report_mismatch("invalidate_page", 64'(want.invalidate), 64'(invalidate_page));
                if (tables_added !== want.added)
                    report_mismatch("tables_added", 64'(want.added), 64'(tables_added));
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_walks();
        test_table_base_wrap();
        test_random_traffic(33, rand36(), RANDOM_ITEMS);
        test_random_traffic(75, rand36(), RANDOM_ITEMS);
        test_random_traffic(0, '0, RANDOM_ITEMS);
        test_table_exhaustion();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d map and %0d unmap requests, %0d results checked, %0d mismatches",
                 sent_map, sent_unmap, outcomes_seen, mismatches);
        $display("%0d tables allocated, %0d out-of-pages rejections, %0d table base writes",
                 tables_made, no_page_rejects, base_writes);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
